>>> hw/rtl/tsts_pkg.sv
// ----------------------------------------------------------------------------
// tsts_pkg
// shared types and codes for the two-key sorted table search unit
// ----------------------------------------------------------------------------
package tsts_pkg;

    localparam int TYPE_W = 8;
    localparam int ID_W   = 16;
    localparam int DATA_W = 24;
    localparam int POS_W  = 9;
    localparam int KEY_W  = TYPE_W + ID_W;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_FULL     = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [TYPE_W-1:0] type_id;
        logic [ID_W-1:0]   resource_id;
        logic [DATA_W-1:0] entry_offset;
        logic [DATA_W-1:0] entry_length;
    } entry_t;

    typedef struct packed {
        logic start;
        logic step;
    } probe_ctrl_t;

    typedef struct packed {
        logic pending;
        logic hit;
    } probe_stat_t;

endpackage

>>> hw/rtl/tsts_table_mem.sv
// ----------------------------------------------------------------------------
// tsts_table_mem
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tsts_table_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  tsts_pkg::entry_t    wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output tsts_pkg::entry_t    rd_data
);

    tsts_pkg::entry_t mem [DEPTH];
    tsts_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/tsts_probe_unit.sv
// ----------------------------------------------------------------------------
// tsts_probe_unit
// binary search bounds and the shared compound key compare
// ----------------------------------------------------------------------------
module tsts_probe_unit #(
    parameter int CW = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsts_pkg::probe_ctrl_t       ctrl,
    input  logic [CW-1:0]               count,
    input  logic [tsts_pkg::KEY_W-1:0]  key_in,
    input  logic [tsts_pkg::KEY_W-1:0]  entry_key,
    output logic [CW-1:0]               lo,
    output logic [CW-1:0]               mid,
    output tsts_pkg::probe_stat_t       stat
);

    logic [CW-1:0]              lo_reg;
    logic [CW-1:0]              lo_next;
    logic [CW-1:0]              hi_reg;
    logic [CW-1:0]              hi_next;
    logic [tsts_pkg::KEY_W-1:0] key_reg;
    logic [CW:0]                bound_sum;
    logic                       key_below;

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = bound_sum[CW:1];
    assign key_below = key_reg < entry_key;

    assign stat.pending = lo_reg < hi_reg;
    assign stat.hit     = key_reg == entry_key;

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.start)
        begin
            lo_next = '0;
            hi_next = count;
        end
        else if (ctrl.step && !stat.hit)
        begin
            if (key_below)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            key_reg <= key_in;
        end
    end

    assign lo = lo_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) lo_reg <= hi_reg)
        else $error("search bounds crossed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && !ctrl.start && !stat.hit && stat.pending)
            |=> ((hi_reg - lo_reg) < $past(hi_reg - lo_reg)))
        else $error("search range did not shrink");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> (lo_reg == '0))
        else $error("search did not start at the low end");
`endif

endmodule

>>> hw/rtl/two_key_sorted_table_search_unit.sv
// ----------------------------------------------------------------------------
// two_key_sorted_table_search_unit
// sorted (type, id) resource table with binary search lookup
//
// one command word in, one result word out. append writes the next entry and
// clear empties the table; each is taken in the accept cycle and then passes
// through the done state. a lookup runs at most ceil(log2(entries + 1))
// probes, each a registered read of the table memory at the midpoint in the
// check state, then the key compare in the probe unit in the compare state;
// a hit ends the search early. a finished result waits in the done state
// while the output register is stalled. the table needs no clearing pass
// after reset. a result waits in the output register while the next command
// word is taken.
// ----------------------------------------------------------------------------
module two_key_sorted_table_search_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      command,
    input  logic [tsts_pkg::TYPE_W-1:0]     type_id,
    input  logic [tsts_pkg::ID_W-1:0]       resource_id,
    input  logic [tsts_pkg::DATA_W-1:0]     entry_offset,
    input  logic [tsts_pkg::DATA_W-1:0]     entry_length,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [2:0]                      status,
    output logic [tsts_pkg::POS_W-1:0]      position,
    output logic [tsts_pkg::DATA_W-1:0]     found_offset,
    output logic [tsts_pkg::DATA_W-1:0]     found_length
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = (CW > tsts_pkg::POS_W) ? CW : tsts_pkg::POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;

    tsts_pkg::status_t              res_status_reg;
    tsts_pkg::status_t              res_status_next;
    logic [tsts_pkg::POS_W-1:0]     res_pos_reg;
    logic [tsts_pkg::POS_W-1:0]     res_pos_next;
    logic [tsts_pkg::DATA_W-1:0]    res_off_reg;
    logic [tsts_pkg::DATA_W-1:0]    res_off_next;
    logic [tsts_pkg::DATA_W-1:0]    res_len_reg;
    logic [tsts_pkg::DATA_W-1:0]    res_len_next;

    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    tsts_pkg::status_t              rsp_status_reg;
    logic [tsts_pkg::POS_W-1:0]     rsp_pos_reg;
    logic [tsts_pkg::DATA_W-1:0]    rsp_off_reg;
    logic [tsts_pkg::DATA_W-1:0]    rsp_len_reg;

    logic                           req_take;
    logic                           rsp_free;
    logic                           rsp_load;
    logic                           wr_en;
    tsts_pkg::entry_t               wr_data;
    logic                           rd_en;
    tsts_pkg::entry_t               rd_data;
    tsts_pkg::probe_ctrl_t          probe_ctrl;
    tsts_pkg::probe_stat_t          probe_stat;
    logic [CW-1:0]                  probe_lo;
    logic [CW-1:0]                  probe_mid;

    function automatic logic [tsts_pkg::POS_W-1:0] to_pos(input logic [CW-1:0] v);
        logic [PW-1:0] wide;
        wide = PW'(v);
        return wide[tsts_pkg::POS_W-1:0];
    endfunction

    assign req_stall = state_reg != S_IDLE;
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_load  = (state_reg == S_DONE) && rsp_free;

    assign wr_data.type_id      = type_id;
    assign wr_data.resource_id  = resource_id;
    assign wr_data.entry_offset = entry_offset;
    assign wr_data.entry_length = entry_length;

    tsts_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (probe_mid[AW-1:0]),
        .rd_data (rd_data)
    );

    tsts_probe_unit #(
        .CW (CW)
    ) u_probe (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (probe_ctrl),
        .count     (count_reg),
        .key_in    ({type_id, resource_id}),
        .entry_key ({rd_data.type_id, rd_data.resource_id}),
        .lo        (probe_lo),
        .mid       (probe_mid),
        .stat      (probe_stat)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        res_status_next  = res_status_reg;
        res_pos_next     = res_pos_reg;
        res_off_next     = res_off_reg;
        res_len_next     = res_len_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        probe_ctrl.start = 1'b0;
        probe_ctrl.step  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    res_off_next = '0;
                    res_len_next = '0;
                    unique case (command)
                        tsts_pkg::CMD_APPEND:
                        begin
                            res_pos_next = to_pos(count_reg);
                            if (count_reg == FULL_COUNT)
                            begin
                                res_status_next = tsts_pkg::ST_FULL;
                            end
                            else
                            begin
                                res_status_next = tsts_pkg::ST_APPENDED;
                                wr_en           = 1'b1;
                                count_next      = count_reg + CW'(1);
                            end
                            state_next = S_DONE;
                        end
                        tsts_pkg::CMD_CLEAR:
                        begin
                            res_status_next = tsts_pkg::ST_CLEARED;
                            res_pos_next    = '0;
                            count_next      = '0;
                            state_next      = S_DONE;
                        end
                        default:
                        begin
                            probe_ctrl.start = 1'b1;
                            state_next       = S_CHECK;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (probe_stat.pending)
                begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    res_status_next = tsts_pkg::ST_MISSING;
                    res_pos_next    = to_pos(probe_lo);
                    state_next      = S_DONE;
                end
            end
            S_CMP:
            begin
                probe_ctrl.step = 1'b1;
                if (probe_stat.hit)
                begin
                    res_status_next = tsts_pkg::ST_FOUND;
                    res_pos_next    = to_pos(probe_mid);
                    res_off_next    = rd_data.entry_offset;
                    res_len_next    = rd_data.entry_length;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_off_reg    <= res_off_next;
        res_len_reg    <= res_len_next;
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_pos_reg    <= res_pos_reg;
            rsp_off_reg    <= res_off_reg;
            rsp_len_reg    <= res_len_reg;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign position     = rsp_pos_reg;
    assign found_offset = rsp_off_reg;
    assign found_length = rsp_len_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("entry count beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_CHECK))
        else $error("compare without a preceding read");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result word raised outside the done state");
`endif

endmodule
